[rtl/core/dca_pkg.sv]
// Shared types and constants for the delay, comb and allpass unit.
// Holds register index codes, mode codes, arithmetic unit operations and sequencer states.
// No dependencies.
package dca_pkg;

	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 15;
	localparam int DELAY_W    = 20;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [MODE_W-1:0] mode_t;

	// The spare code behaves as plain delay.
	localparam mode_t MODE_PLAIN   = 2'd0;
	localparam mode_t MODE_COMB    = 2'd1;
	localparam mode_t MODE_ALLPASS = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_INTERP = 2'd1,
		REG_GAIN   = 2'd2,
		REG_LENGTH = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ALU_INTERP   = 2'd0,
		ALU_FEED     = 2'd1,
		ALU_FEED_NEG = 2'd2
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'd0,
		ST_IDLE   = 3'd1,
		ST_SETUP  = 3'd2,
		ST_RDA    = 3'd3,
		ST_RDB    = 3'd4,
		ST_INTERP = 3'd5,
		ST_GAIN   = 3'd6,
		ST_DONE   = 3'd7
	} state_t;

endpackage

[rtl/core/dca_if.sv]
// Valid/ready channel interfaces for the delay, comb and allpass unit.
// Depends on dca_pkg for field widths.
interface dca_in_if import dca_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [DELAY_W-1:0]            delay_samples;

	modport source (output valid, output sample_in, output delay_samples, input ready);
	modport sink (input valid, input sample_in, input delay_samples, output ready);
endinterface

interface dca_out_if import dca_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface dca_cfg_if import dca_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/dca_store.sv]
// Single-port delay store with registered read data.
// No dependencies; one access per cycle, write or read.
module dca_store #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 24,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/core/dca_alu.sv]
// Shared multiply, shift and saturating add/subtract unit of the delay, comb and allpass unit.
// Depends on dca_pkg for the operation codes and gain width.
module dca_alu import dca_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 8
) (
	input  alu_op_t                       op,
	input  logic signed [SAMPLE_BITS:0]   mul_a,
	input  logic signed [GAIN_W:0]        mul_b,
	input  logic signed [SAMPLE_BITS-1:0] addend,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PW = SAMPLE_BITS + GAIN_W + 2;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] shifted;
	logic signed [SW-1:0] sum;

	always_comb begin
		prod = PW'(mul_a) * PW'(mul_b);
		// Arithmetic shifts round toward minus infinity.
		unique case (op)
			ALU_INTERP: begin
				shifted = prod >>> FRAC_BITS;
				sum     = SW'(addend) + SW'(shifted);
			end
			ALU_FEED: begin
				shifted = prod >>> GAIN_FRAC;
				sum     = SW'(addend) + SW'(shifted);
			end
			ALU_FEED_NEG: begin
				shifted = prod >>> GAIN_FRAC;
				sum     = SW'(addend) - SW'(shifted);
			end
			default: begin
				shifted = '0;
				sum     = SW'(addend);
			end
		endcase

		if (sum > SAT_HI) begin
			result = SAT_HI[SAMPLE_BITS-1:0];
		end else if (sum < SAT_LO) begin
			result = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			result = sum[SAMPLE_BITS-1:0];
		end
	end

endmodule

[rtl/core/delay_comb_allpass_unit.sv]
// Delay line with plain delay, feedback comb and allpass modes over a circular store.
// Items are processed one at a time: a new input is taken only after the last one leaves the
// done state, since the single store port (up to three accesses) and the one shared
// multiplier (used three times) serve each item. After reset the store is swept to zero, one
// entry per cycle, across STORE_DEPTH entries (4096 by default) before the first input is taken;
// configuration writes are accepted throughout. Depends on dca_pkg, dca_if, dca_store, dca_alu.
module delay_comb_allpass_unit import dca_pkg::*; #(
	parameter int STORE_DEPTH = 4096,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 8
) (
	input logic      clk,
	input logic      arst_n,
	dca_cfg_if.sink  cfg,
	dca_in_if.sink   din,
	dca_out_if.source dout
);

	localparam int PTR_W = $clog2(STORE_DEPTH);
	localparam int LEN_W = PTR_W + 1;
	localparam int FW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
	localparam int DW    = DELAY_W + LEN_W + FRAC_BITS;

	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(STORE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(STORE_DEPTH - 1);
	localparam logic [DW-1:0]    D_ONE     = DW'(64'd1 << FRAC_BITS);
	localparam logic [FW-1:0]    FRAC_MASK = FW'((64'd1 << FRAC_BITS) - 64'd1);

	// Configuration registers.
	mode_t                    mode_q;
	logic                     interp_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [LEN_W-1:0]         len_q;

	// Sequencer and control state.
	state_t           state_q;
	state_t           state_d;
	logic [PTR_W-1:0] clr_q;
	logic [PTR_W-1:0] wptr_q;
	logic             out_valid_q;
	logic             done_go;

	// Per-item working registers.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [DELAY_W-1:0]            d_q;
	logic [PTR_W-1:0]              wp_q;
	logic [LEN_W-1:0]              ip_q;
	logic [FW-1:0]                 frac_q;
	logic [PTR_W-1:0]              rp_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] w_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	// Combinational address and clamp logic.
	logic [LEN_W-1:0] len_eff;
	logic [PTR_W-1:0] wp_eff;
	logic [PTR_W-1:0] rp;
	logic [LEN_W-1:0] wp_inc;
	logic [DW-1:0]    d_min;
	logic [DW-1:0]    d_max;
	logic [DW-1:0]    d_cl;

	// Store and arithmetic unit connections.
	logic                          mem_we;
	logic [PTR_W-1:0]              mem_addr;
	logic signed [SAMPLE_BITS-1:0] mem_wdata;
	logic signed [SAMPLE_BITS-1:0] mem_rdata;
	alu_op_t                       alu_op;
	logic signed [SAMPLE_BITS:0]   mul_a;
	logic signed [GAIN_W:0]        mul_b;
	logic signed [SAMPLE_BITS-1:0] alu_addend;
	logic signed [SAMPLE_BITS-1:0] alu_result;

	// Steps back from pos by back entries, wrapping at len.
	function automatic logic [PTR_W-1:0] wrap_back(input logic [PTR_W-1:0] pos,
			input logic [LEN_W-1:0] back, input logic [LEN_W-1:0] len);
		logic [LEN_W:0] pos_x;
		logic [LEN_W:0] res;
		pos_x = (LEN_W+1)'(pos);
		if (pos_x >= (LEN_W+1)'(back)) begin
			res = pos_x - (LEN_W+1)'(back);
		end else begin
			res = pos_x + (LEN_W+1)'(len) - (LEN_W+1)'(back);
		end
		return res[PTR_W-1:0];
	endfunction

	dca_store #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	dca_alu #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_alu (
		.op     (alu_op),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.addend (alu_addend),
		.result (alu_result)
	);

	// The configuration channel never stalls. The user must issue writes only while no item is
	// in flight, so the registers stay steady across an item; the block does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			interp_q <= 1'b0;
			gain_q   <= '0;
			len_q    <= LEN_MAX;
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.index))
				REG_MODE:   mode_q   <= cfg.data[MODE_W-1:0];
				REG_INTERP: interp_q <= cfg.data[0];
				REG_GAIN:   gain_q   <= cfg.data[GAIN_W-1:0];
				REG_LENGTH: len_q    <= cfg.data[LEN_W-1:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	// The line length in use is clamped to the range the store supports, and a write
	// pointer left beyond a shortened line restarts at entry zero.
	always_comb begin
		if (len_q < LEN_MIN) begin
			len_eff = LEN_MIN;
		end else if (len_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = len_q;
		end

		wp_eff = (LEN_W'(wptr_q) >= len_eff) ? '0 : wptr_q;
		wp_inc = LEN_W'(wp_q) + LEN_W'(1);

		// Allpass never reads at zero delay; every mode saturates the delay to one
		// entry short of the line, which also drops the fraction.
		d_min = (mode_q == MODE_ALLPASS && DW'(d_q) < D_ONE) ? D_ONE : DW'(d_q);
		d_max = DW'(len_eff - LEN_W'(1)) << FRAC_BITS;
		d_cl  = (d_min > d_max) ? d_max : d_min;

		rp = wrap_back(wp_q, ip_q, len_eff);
	end

	// Sequencer: next state, store access and arithmetic unit operand selection.
	always_comb begin
		state_d    = state_q;
		din.ready  = 1'b0;
		done_go    = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = wp_q;
		mem_wdata  = w_q;
		alu_op     = ALU_FEED;
		mul_a      = (SAMPLE_BITS+1)'(rd_q);
		mul_b      = (GAIN_W+1)'(gain_q);
		alu_addend = x_q;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				// Plain delay (and the spare mode code) writes before it reads.
				mem_we    = (mode_q != MODE_COMB) && (mode_q != MODE_ALLPASS);
				mem_addr  = wp_eff;
				mem_wdata = x_q;
				state_d   = ST_RDA;
			end
			ST_RDA: begin
				mem_addr = rp;
				state_d  = ST_RDB;
			end
			ST_RDB: begin
				mem_addr = wrap_back(rp_q, LEN_W'(1), len_eff);
				state_d  = ST_INTERP;
			end
			ST_INTERP: begin
				// The neighbor is on the read port now; with a zero fraction the
				// product vanishes and the near entry passes unchanged.
				alu_op     = ALU_INTERP;
				mul_a      = (SAMPLE_BITS+1)'(mem_rdata) - (SAMPLE_BITS+1)'(a_q);
				mul_b      = (GAIN_W+1)'(frac_q);
				alu_addend = a_q;
				state_d    = ST_GAIN;
			end
			ST_GAIN: begin
				alu_op     = ALU_FEED;
				mul_a      = (SAMPLE_BITS+1)'(rd_q);
				alu_addend = x_q;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				alu_op     = ALU_FEED_NEG;
				mul_a      = (SAMPLE_BITS+1)'(w_q);
				alu_addend = rd_q;
				mem_we     = (mode_q == MODE_COMB) || (mode_q == MODE_ALLPASS);
				mem_addr   = wp_q;
				mem_wdata  = w_q;
				// Hold here while the previous result still waits to be taken.
				if (!out_valid_q || dout.ready) begin
					done_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			wptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PTR_W'(1);
			end
			if (done_go) begin
				wptr_q      <= (wp_inc >= len_eff) ? '0 : wp_inc[PTR_W-1:0];
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers carry no reset; each is written before it is used.
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			x_q <= din.sample_in;
			d_q <= din.delay_samples;
		end
		if (state_q == ST_SETUP) begin
			wp_q   <= wp_eff;
			ip_q   <= LEN_W'(d_cl >> FRAC_BITS);
			frac_q <= interp_q ? (d_cl[FW-1:0] & FRAC_MASK) : '0;
		end
		if (state_q == ST_RDA) begin
			rp_q <= rp;
		end
		if (state_q == ST_RDB) begin
			a_q <= mem_rdata;
		end
		if (state_q == ST_INTERP) begin
			rd_q <= alu_result;
		end
		if (state_q == ST_GAIN) begin
			w_q <= alu_result;
		end
		if (done_go) begin
			out_q <= (mode_q == MODE_ALLPASS) ? alu_result : rd_q;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_q;

`ifndef SYNTH
	a_wptr_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		done_go |=> (LEN_W'(wptr_q) < $past(len_eff)))
		else $error("write pointer left the line after an item");

	a_read_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDB) |-> (LEN_W'(rp_q) < len_eff))
		else $error("read position outside the line in use");

	a_allpass_min_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDA && mode_q == MODE_ALLPASS) |-> (ip_q != '0))
		else $error("allpass read at zero whole-sample delay");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_SETUP || state_q == ST_DONE))
		else $error("store written outside a write step");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished item");
`endif

endmodule
